/* design/beq_pkg.sv */
// Shared types and constants for the three-stage biquad equalizer.
package beq_pkg;

  localparam int STAGES    = 3;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_B  = 3'd0,
    REG_LOW_A  = 3'd1,
    REG_PEAK_B = 3'd2,
    REG_PEAK_A = 3'd3,
    REG_HIGH_B = 3'd4,
    REG_HIGH_A = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_MAC,
    CS_RND,
    CS_HOLD
  } cell_state_t;

  typedef enum logic [2:0] {
    TAP_B0,
    TAP_B1,
    TAP_B2,
    TAP_A1,
    TAP_A2,
    TAP_END
  } tap_t;

  typedef struct packed {
    logic valid;
    logic bypass;
    logic chan;
  } cell_ctl_t;

endpackage

/* design/beq_if.sv */
// Valid/ready stream interfaces for the equalizer's sample channels.
interface beq_in_if #(parameter int SAMPLE_WIDTH = 24) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           channel;

  modport source (output valid, sample_in, channel, input ready);
  modport sink   (input valid, sample_in, channel, output ready);
endinterface

interface beq_out_if #(parameter int SAMPLE_WIDTH = 24) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

/* design/beq_cell.sv */
// One biquad cell: serial MAC over five taps, round and saturate (or bypass), hand on.
module beq_cell import beq_pkg::*; #(
  parameter int CHANNELS     = 2,
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cell_ctl_t                      in_ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                           in_ready,
  input  logic [3*COEF_WIDTH-1:0]        coef_b,
  input  logic [2*COEF_WIDTH-1:0]        coef_a,
  output cell_ctl_t                      out_ctl,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample,
  input  logic                           out_ready
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int CW   = COEF_WIDTH;
  localparam int PW   = SW + CW;
  localparam int AW   = PW + 3;
  localparam int FRAC = CW - 4;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic signed [AW-1:0] RND_HALF = AW'(1) << (FRAC - 1);
  localparam logic signed [AW-1:0] SAT_HI   = $signed({{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}});
  localparam logic signed [AW-1:0] SAT_LO   = ~SAT_HI;

  cell_state_t state_r, state_nxt;
  tap_t        tap_r;
  logic        prod_vld_r;
  logic        neg_r;
  logic        bypass_r;
  logic        chan_r;
  logic        accept;
  logic        out_vld;

  logic signed [SW-1:0] x_r;
  logic signed [SW-1:0] y_r;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] addend;
  logic signed [AW-1:0] acc_rnd;
  logic signed [AW-1:0] acc_sh;
  logic signed [SW-1:0] y_sat;
  logic signed [CW-1:0] c_sel;
  logic signed [SW-1:0] d_sel;
  logic [CH_W-1:0]      ch_idx;

  logic signed [SW-1:0] xh1_r [CHANNELS];
  logic signed [SW-1:0] xh2_r [CHANNELS];
  logic signed [SW-1:0] yh1_r [CHANNELS];
  logic signed [SW-1:0] yh2_r [CHANNELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_vld   = 1'b0;
    case (state_r)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_ctl.valid) state_nxt = CS_MAC;
      end
      CS_MAC: begin
        if (tap_r == TAP_END) state_nxt = CS_RND;
      end
      CS_RND: begin
        state_nxt = CS_HOLD;
      end
      CS_HOLD: begin
        out_vld = 1'b1;
        if (out_ready) state_nxt = CS_IDLE;
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  assign accept         = in_ready && in_ctl.valid;
  assign out_ctl.valid  = out_vld;
  assign out_ctl.bypass = bypass_r;
  assign out_ctl.chan   = chan_r;
  assign out_sample     = y_r;
  assign ch_idx         = CH_W'(chan_r);

  // pick coefficient and operand for the current tap
  always_comb begin
    case (tap_r)
      TAP_B0: begin
        c_sel = coef_b[3*CW-1:2*CW];
        d_sel = x_r;
      end
      TAP_B1: begin
        c_sel = coef_b[2*CW-1:CW];
        d_sel = xh1_r[ch_idx];
      end
      TAP_B2: begin
        c_sel = coef_b[CW-1:0];
        d_sel = xh2_r[ch_idx];
      end
      TAP_A1: begin
        c_sel = coef_a[2*CW-1:CW];
        d_sel = yh1_r[ch_idx];
      end
      TAP_A2: begin
        c_sel = coef_a[CW-1:0];
        d_sel = yh2_r[ch_idx];
      end
      default: begin
        c_sel = '0;
        d_sel = '0;
      end
    endcase
  end

  assign prod_nxt = c_sel * d_sel;
  assign addend   = neg_r ? -AW'(prod_r) : AW'(prod_r);

  // round half up, then saturate to the sample range
  assign acc_rnd = acc_r + RND_HALF;
  assign acc_sh  = acc_rnd >>> FRAC;

  always_comb begin
    if (acc_sh > SAT_HI) begin
      y_sat = SAT_HI[SW-1:0];
    end else if (acc_sh < SAT_LO) begin
      y_sat = SAT_LO[SW-1:0];
    end else begin
      y_sat = acc_sh[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r      <= TAP_B0;
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= (state_r == CS_MAC) && (tap_r != TAP_END);
      if (accept) begin
        tap_r <= TAP_B0;
      end else if ((state_r == CS_MAC) && (tap_r != TAP_END)) begin
        tap_r <= tap_t'(tap_r + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    neg_r  <= (tap_r == TAP_A1) || (tap_r == TAP_A2);
    if (accept) begin
      x_r      <= in_sample;
      bypass_r <= in_ctl.bypass;
      chan_r   <= in_ctl.chan;
      acc_r    <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + addend;
    end
    if (state_r == CS_RND) begin
      y_r <= bypass_r ? x_r : y_sat;
    end
  end

  // history sets, one per channel; untouched for a channel without one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        xh1_r[i] <= '0;
        xh2_r[i] <= '0;
        yh1_r[i] <= '0;
        yh2_r[i] <= '0;
      end
    end else if ((state_r == CS_RND) && !bypass_r) begin
      xh2_r[ch_idx] <= xh1_r[ch_idx];
      xh1_r[ch_idx] <= x_r;
      yh2_r[ch_idx] <= yh1_r[ch_idx];
      yh1_r[ch_idx] <= y_sat;
    end
  end

`ifndef SYNTHESIS
  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == CS_MAC) && (tap_r == TAP_B0) && (acc_r == '0))
    else $error("cell did not start a clean accumulation");

  a_last_tap: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == CS_MAC) && (tap_r == TAP_END)) |=> (state_r == CS_RND))
    else $error("cell did not round after the last tap");

  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CS_RND) |-> !prod_vld_r)
    else $error("product still in flight at rounding");

  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == CS_RND) && bypass_r) |=> (out_sample == $past(x_r)))
    else $error("bypassed word was altered");
`endif

endmodule

/* design/three_stage_biquad_equalizer.sv */
// Top level: coefficient registers, a chain of three biquad cells and the output register.
//
//   channel   dir  handshake      payload
//   in_word   in   valid/ready    sample_in (SAMPLE_WIDTH, signed), channel (1 bit)
//   out_word  out  valid/ready    sample_out (SAMPLE_WIDTH, signed)
//   cfg       in   cfg_we         cfg_index (3 bits), cfg_data (3*COEF_WIDTH bits)
//
// Each cell runs five multiply-accumulates on its single multiplier, then rounds;
// a cell takes no new word until it has handed on its last, so the chain holds
// at most one word per cell and one in the output register.
// Synchronous reset clears histories and sets every stage to pass-through.
// A stalled output holds the word in the output register; the cells behind it hold too.
module three_stage_biquad_equalizer import beq_pkg::*; #(
  parameter int CHANNELS     = 2,
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  beq_in_if.sink                  in_word,
  beq_out_if.source               out_word,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [3*COEF_WIDTH-1:0] cfg_data
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int CW = COEF_WIDTH;

  // b0 = 1.0 in the top slot, b1 = b2 = 0
  localparam logic [3*CW-1:0] B_RST = (3*CW)'(1) << (2*CW + CW - 4);

  logic [3*CW-1:0] coef_b_r [STAGES];
  logic [2*CW-1:0] coef_a_r [STAGES];

  cell_ctl_t            ctl [STAGES+1];
  logic signed [SW-1:0] smp [STAGES+1];
  logic                 rdy [STAGES+1];

  logic                 out_valid_r;
  logic signed [SW-1:0] out_sample_r;
  logic                 take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STAGES; i++) begin
        coef_b_r[i] <= B_RST;
        coef_a_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_B:  coef_b_r[0] <= cfg_data;
        REG_LOW_A:  coef_a_r[0] <= cfg_data[2*CW-1:0];
        REG_PEAK_B: coef_b_r[1] <= cfg_data;
        REG_PEAK_A: coef_a_r[1] <= cfg_data[2*CW-1:0];
        REG_HIGH_B: coef_b_r[2] <= cfg_data;
        REG_HIGH_A: coef_a_r[2] <= cfg_data[2*CW-1:0];
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  assign ctl[0].valid  = in_word.valid;
  assign ctl[0].chan   = in_word.channel;
  assign ctl[0].bypass = 32'(in_word.channel) >= 32'(CHANNELS);
  assign smp[0]        = in_word.sample_in;
  assign in_word.ready = rdy[0];

  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    beq_cell #(
      .CHANNELS     (CHANNELS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_ctl     (ctl[g]),
      .in_sample  (smp[g]),
      .in_ready   (rdy[g]),
      .coef_b     (coef_b_r[g]),
      .coef_a     (coef_a_r[g]),
      .out_ctl    (ctl[g+1]),
      .out_sample (smp[g+1]),
      .out_ready  (rdy[g+1])
    );
  end

  // output register: advance when empty or being taken
  assign rdy[STAGES] = !out_valid_r || out_word.ready;
  assign take        = ctl[STAGES].valid && rdy[STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_sample_r <= smp[STAGES];
  end

  assign out_word.valid      = out_valid_r;
  assign out_word.sample_out = out_sample_r;

endmodule
